// ----- rtl/core/weno5_interface_flux_assert.svh -----
// Assertion macros used by the checker file of the WENO5 flux block.
// Expects clk and rst_n in the scope of each use.
`ifndef WENO5_INTERFACE_FLUX_ASSERT_SVH
`define WENO5_INTERFACE_FLUX_ASSERT_SVH

// same-cycle implication
`define WF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define WF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- rtl/core/wenof_pkg.sv -----
// Types and fixed widths of the WENO5 interface flux datapath.
// No dependencies; used by the top level, the divider and the checker.
package wenof_pkg;

    localparam int EPS_BITS   = 16;
    localparam int IND_BITS   = 15;
    localparam int Q_BITS     = 2 * IND_BITS;
    localparam int M_BITS     = 2 * Q_BITS;
    localparam int N_BITS     = 64;
    localparam int SUM_BITS   = 32;
    localparam int WGT_BITS   = 30;
    localparam int QUO_BITS   = 28;
    localparam int DEN_BITS   = 35;
    localparam int REM_BITS   = 36;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = QUO_BITS / DIV_STEPS;
    localparam int LATENCY    = DIV_STAGES + 14;

    localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd1;

    typedef logic [SUM_BITS-1:0] num_t;
    typedef logic [DEN_BITS-1:0] den_t;
    typedef logic [QUO_BITS-1:0] quo_t;
    typedef logic [REM_BITS-1:0] rem_t;

endpackage

// ----- rtl/core/wenof_div.sv -----
// Pipelined restoring divider for the three normalized weights.
// Depends on wenof_pkg; DIV_STEPS quotient bits per stage.
module wenof_div
    import wenof_pkg::*;
(
    input  logic clk,
    input  num_t num [3],
    input  den_t den,
    output quo_t quo [3]
);

    rem_t rem_reg [DIV_STAGES][3];
    quo_t quo_reg [DIV_STAGES][3];
    den_t den_reg [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_st
        rem_t rem_in [3];
        quo_t quo_in [3];
        den_t den_in;
        rem_t rem_next [3];
        quo_t quo_next [3];

        if (g == 0)
        begin : g_first
            always_comb
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rem_in[k] = REM_BITS'({num[k], 2'b00});
                    quo_in[k] = '0;
                end
                den_in = den;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rem_in[k] = rem_reg[g-1][k];
                    quo_in[k] = quo_reg[g-1][k];
                end
                den_in = den_reg[g-1];
            end
        end

        always_comb
        begin
            rem_t r;
            quo_t q;
            for (int k = 0; k < 3; k++)
            begin
                r = rem_in[k];
                q = quo_in[k];
                for (int s = 0; s < DIV_STEPS; s++)
                begin
                    r = {r[REM_BITS-2:0], 1'b0};
                    if (r >= REM_BITS'(den_in))
                    begin
                        r = r - REM_BITS'(den_in);
                        q = {q[QUO_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[QUO_BITS-2:0], 1'b0};
                    end
                end
                rem_next[k] = r;
                quo_next[k] = q;
            end
        end

        always_ff @(posedge clk)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[g][k] <= rem_next[k];
                quo_reg[g][k] <= quo_next[k];
            end
            den_reg[g] <= den_in;
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

// ----- rtl/core/weno5_interface_flux.sv -----
// WENO5 interface flux: upwind stencil select, smoothness indicators,
// nonlinear weights and saturated blend. Depends on wenof_pkg, wenof_div.
//
//  channel   handshake              payload
//  request   start / busy           flux_m2..flux_p3, cons_here, cons_next
//  result    result_valid strobe    interface_flux, saturated
//  config    cfg_valid / cfg_ready  cfg_data (epsilon)
//
// One request per cycle; result_valid is raised as each result leaves the pipe.
// The weight divider, two quotient bits a stage, makes up a large part of the pipe.
// busy never rises and cfg_ready is always high; the pipe never stalls.
// Reset clears the valid bits and sets epsilon to 1.
module weno5_interface_flux
    import wenof_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] flux_m2,
    input  logic signed [DATA_WIDTH-1:0] flux_m1,
    input  logic signed [DATA_WIDTH-1:0] flux_c0,
    input  logic signed [DATA_WIDTH-1:0] flux_p1,
    input  logic signed [DATA_WIDTH-1:0] flux_p2,
    input  logic signed [DATA_WIDTH-1:0] flux_p3,
    input  logic signed [DATA_WIDTH-1:0] cons_here,
    input  logic signed [DATA_WIDTH-1:0] cons_next,
    output logic                         result_valid,
    output logic signed [DATA_WIDTH-1:0] interface_flux,
    output logic                         saturated,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [EPS_BITS-1:0]          cfg_data
);

    localparam int PRE   = (DATA_WIDTH > 56) ? DATA_WIDTH - 56 : 0;
    localparam int SW    = DATA_WIDTH - PRE;
    localparam int PW    = SW + 5;
    localparam int XW    = SW + 4;
    localparam int XL    = XW / 2;
    localparam int XH    = XW - XL;
    localparam int EPSW  = EPS_BITS + 4 + FRAC_BITS;
    localparam int EW    = ((2 * XW + 5) > EPSW) ? (2 * XW + 5) : EPSW;
    localparam int EWX   = EW + 1;
    localparam int BLW   = $clog2(EW + 1);
    localparam int SHW   = $clog2(N_BITS + 1);
    localparam int PL    = PW / 2;
    localparam int PH    = PW - PL;
    localparam int WLW   = QUO_BITS + PL + 2;
    localparam int WHW   = QUO_BITS + 1 + PH;
    localparam int ACW   = QUO_BITS + PW + 3;
    localparam int RSH   = WGT_BITS - PRE;
    localparam int P_DLY = DIV_STAGES + 10;

    logic [EPS_BITS-1:0] eps_reg;
    logic                vld_reg [LATENCY];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
            for (int i = 0; i < LATENCY; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                eps_reg <= cfg_data;
            end
            vld_reg[0] <= start && !busy;
            for (int i = 1; i < LATENCY; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // stage 1: upwind select
    logic signed [DATA_WIDTH-1:0] fin [6];
    logic                         left;
    logic signed [SW-1:0]         s1_reg [5];

    assign fin[0] = flux_m2;
    assign fin[1] = flux_m1;
    assign fin[2] = flux_c0;
    assign fin[3] = flux_p1;
    assign fin[4] = flux_p2;
    assign fin[5] = flux_p3;

    always_comb
    begin
        logic gt_f, lt_f, gt_u, lt_u;
        gt_f = flux_c0 > flux_p1;
        lt_f = flux_c0 < flux_p1;
        gt_u = cons_here > cons_next;
        lt_u = cons_here < cons_next;
        left = (gt_f && gt_u) || (lt_f && lt_u) || (!gt_u && !lt_u && gt_f);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 5; k++)
        begin
            s1_reg[k] <= left ? SW'(fin[k] >>> PRE) : SW'(fin[5-k] >>> PRE);
        end
    end

    // stage 2: candidates and indicator terms
    logic signed [PW-1:0] se [5];
    logic signed [XW-1:0] xe [5];
    logic signed [PW-1:0] p_dly_reg [P_DLY][3];
    logic signed [XW-1:0] x_reg [6];

    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            se[k] = PW'(s1_reg[k]);
            xe[k] = XW'(s1_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        p_dly_reg[0][0] <= se[0] * 2 - se[1] * 7 + se[2] * 11;
        p_dly_reg[0][1] <= se[2] * 5 - se[1] + se[3] * 2;
        p_dly_reg[0][2] <= se[2] * 2 + se[3] * 5 - se[4];
        x_reg[0] <= xe[0] - xe[1] * 2 + xe[2];
        x_reg[1] <= xe[0] * 3 - xe[1] * 4 + xe[2];
        x_reg[2] <= xe[1] - xe[2] * 2 + xe[3];
        x_reg[3] <= xe[1] - xe[3];
        x_reg[4] <= xe[2] - xe[3] * 2 + xe[4];
        x_reg[5] <= xe[2] * 3 - xe[3] * 4 + xe[4];
        for (int i = 1; i < P_DLY; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p_dly_reg[i][k] <= p_dly_reg[i-1][k];
            end
        end
    end

    // stage 3: split squares
    logic signed [2*XH-1:0]    hh_reg [6];
    logic signed [XH+XL:0]     hl_reg [6];
    logic        [2*XL-1:0]    ll_reg [6];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 6; j++)
        begin
            hh_reg[j] <= $signed(x_reg[j][XW-1:XL]) * $signed(x_reg[j][XW-1:XL]);
            hl_reg[j] <= $signed(x_reg[j][XW-1:XL]) * $signed({1'b0, x_reg[j][XL-1:0]});
            ll_reg[j] <= x_reg[j][XL-1:0] * x_reg[j][XL-1:0];
        end
    end

    // stage 4: indicators
    logic [EWX-1:0] sq [6];
    logic [EWX-1:0] eps_term;
    logic [EW-1:0]  e_reg [3];

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            sq[j] = (EWX'(hh_reg[j]) << (2 * XL)) + (EWX'(hl_reg[j]) << (XL + 1))
                  + EWX'(ll_reg[j]);
        end
        eps_term = ((EWX'(eps_reg) * EWX'(12)) << FRAC_BITS) >> (2 * PRE);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            e_reg[k] <= EW'(sq[2*k] * EWX'(13) + sq[2*k+1] * EWX'(3) + eps_term);
        end
    end

    // stage 5: common indicator shift
    logic [EW-1:0]  e_or;
    logic [BLW-1:0] e_len;
    logic [BLW-1:0] sh1_reg;
    logic [EW-1:0]  e5_reg [3];

    always_comb
    begin
        e_or  = e_reg[0] | e_reg[1] | e_reg[2];
        e_len = '0;
        for (int i = 0; i < EW; i++)
        begin
            if (e_or[i])
            begin
                e_len = BLW'(i + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sh1_reg <= (e_len > BLW'(IND_BITS)) ? e_len - BLW'(IND_BITS) : '0;
        e5_reg  <= e_reg;
    end

    // stage 6: reduced indicators, floor of one
    logic [EW-1:0]       e_sh [3];
    logic [IND_BITS-1:0] v_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e_sh[k] = e5_reg[k] >> sh1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            v_reg[k] <= (e_sh[k][IND_BITS-1:0] == '0) ? IND_BITS'(1) : e_sh[k][IND_BITS-1:0];
        end
    end

    // stages 7-9: weight numerators
    logic [Q_BITS-1:0] q_reg [3];
    logic [M_BITS-1:0] m_reg [3];
    logic [N_BITS-1:0] n_reg [3];
    logic [N_BITS-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            q_reg[k] <= v_reg[k] * v_reg[k];
        end
        m_reg[0] <= q_reg[1] * q_reg[2];
        m_reg[1] <= q_reg[0] * q_reg[2];
        m_reg[2] <= q_reg[0] * q_reg[1];
        n_reg[0] <= N_BITS'(m_reg[0]);
        n_reg[1] <= N_BITS'(m_reg[1]) * N_BITS'(6);
        n_reg[2] <= N_BITS'(m_reg[2]) * N_BITS'(3);
        sum_reg  <= N_BITS'(m_reg[0]) + N_BITS'(m_reg[1]) * N_BITS'(6)
                  + N_BITS'(m_reg[2]) * N_BITS'(3);
    end

    // stage 10: common numerator shift
    logic [SHW-1:0]    s_len;
    logic [SHW-1:0]    sh2_reg;
    logic [N_BITS-1:0] n10_reg [3];

    always_comb
    begin
        s_len = '0;
        for (int i = 0; i < N_BITS; i++)
        begin
            if (sum_reg[i])
            begin
                s_len = SHW'(i + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sh2_reg <= (s_len > SHW'(SUM_BITS)) ? s_len - SHW'(SUM_BITS) : '0;
        n10_reg <= n_reg;
    end

    // stage 11: divider operands
    logic [N_BITS-1:0] n_sh [3];
    num_t              num_reg [3];
    den_t              den_reg;
    quo_t              quo [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            n_sh[k] = n10_reg[k] >> sh2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            num_reg[k] <= n_sh[k][SUM_BITS-1:0];
        end
        den_reg <= (DEN_BITS'(n_sh[0][SUM_BITS-1:0]) + DEN_BITS'(n_sh[1][SUM_BITS-1:0])
                  + DEN_BITS'(n_sh[2][SUM_BITS-1:0])) * DEN_BITS'(6);
    end

    wenof_div u_div
    (
        .clk (clk),
        .num (num_reg),
        .den (den_reg),
        .quo (quo)
    );

    // blend, shift, saturate
    logic signed [WLW-1:0]        wl_reg [3];
    logic signed [WHW-1:0]        wh_reg [3];
    logic signed [ACW-1:0]        acc_reg;
    logic signed [ACW-1:0]        r_sh;
    logic                         fits;
    logic signed [DATA_WIDTH-1:0] flux_reg;
    logic                         sat_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            wl_reg[k] <= $signed({1'b0, quo[k]})
                       * $signed({1'b0, p_dly_reg[P_DLY-1][k][PL-1:0]});
            wh_reg[k] <= $signed({1'b0, quo[k]}) * $signed(p_dly_reg[P_DLY-1][k][PW-1:PL]);
        end
        acc_reg <= (ACW'(wh_reg[0]) <<< PL) + ACW'(wl_reg[0])
                 + (ACW'(wh_reg[1]) <<< PL) + ACW'(wl_reg[1])
                 + (ACW'(wh_reg[2]) <<< PL) + ACW'(wl_reg[2]);
    end

    always_comb
    begin
        r_sh = acc_reg >>> RSH;
        fits = (&r_sh[ACW-1:DATA_WIDTH-1]) || !(|r_sh[ACW-1:DATA_WIDTH-1]);
    end

    always_ff @(posedge clk)
    begin
        if (fits)
        begin
            flux_reg <= r_sh[DATA_WIDTH-1:0];
        end
        else if (r_sh[ACW-1])
        begin
            flux_reg <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end
        else
        begin
            flux_reg <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        sat_reg <= !fits;
    end

    assign result_valid   = vld_reg[LATENCY-1];
    assign interface_flux = flux_reg;
    assign saturated      = sat_reg;

endmodule

// ----- rtl/core/wenof_chk.sv -----
// Port-level checks of the WENO5 interface flux block, bound to the top.
// Depends on wenof_pkg and weno5_interface_flux_assert.svh.
`include "weno5_interface_flux_assert.svh"

module wenof_chk
    import wenof_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  result_valid,
    input logic [DATA_WIDTH-1:0] interface_flux,
    input logic                  saturated,
    input logic                  cfg_valid,
    input logic                  cfg_ready
);

    localparam logic [DATA_WIDTH-1:0] OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] OUT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // every result traces back to an earlier request at the pipe input
    `WF_ASSERT_IMP(a_result_has_request, result_valid, $past(start, LATENCY))

    // a clipped result sits on a limit
    `WF_ASSERT_IMP(a_sat_at_limit, result_valid && saturated,
        interface_flux == OUT_MAX || interface_flux == OUT_MIN)

    // a request is always taken and leaves the block idle for the next
    `WF_ASSERT_NXT(a_no_stall, start, !busy)

    // config writes are always taken
    `WF_ASSERT_IMP(a_cfg_taken, cfg_valid, cfg_ready)

endmodule

bind weno5_interface_flux wenof_chk #(.DATA_WIDTH(DATA_WIDTH)) u_chk (.*);
